>>> design/ole_pkg.sv
// Shared constants and types of the ordered list engine.
package ole_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 9;
	localparam int LEN_W    = 9;
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [1:0] {
		CMD_APPEND  = 2'd0,
		CMD_INSERT  = 2'd1,
		CMD_DEL_POS = 2'd2,
		CMD_DEL_VAL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

endpackage

>>> design/ole_cmd_if.sv
// Command channel of the ordered list engine.
interface ole_cmd_if;
	logic                                valid;
	logic                                ready;
	ole_pkg::cmd_t                       cmd;
	logic signed [ole_pkg::VALUE_W-1:0]  value;
	logic [ole_pkg::POS_W-1:0]           position;

	modport source (output valid, output cmd, output value, output position, input ready);
	modport sink (input valid, input cmd, input value, input position, output ready);
endinterface

>>> design/ole_rsp_if.sv
// Response channel of the ordered list engine.
interface ole_rsp_if;
	logic                        valid;
	logic                        ready;
	ole_pkg::status_t            status;
	logic [ole_pkg::LEN_W-1:0]   length;

	modport source (output valid, output status, output length, input ready);
	modport sink (input valid, input status, input length, output ready);
endinterface

>>> design/ole_ram.sv
// Generic single write, single read RAM with registered read data.
module ole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/ordered_list_engine.sv
// Ordered list engine: bounded list of 32-bit values with insert and delete commands.
// One command at a time; req.ready is high only while the sequencer is idle.
// Rejected commands go straight to the response; appends and inserts move entries up and deletes
// move or scan entries first. A response waits in S_FIN while the output register still holds
// an unaccepted response. The next command can transfer in the cycle after the response loads.
// Reset clears the count, not the storage.
module ordered_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	ole_cmd_if.sink     req,
	ole_rsp_if.source   rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_PUT,
		S_DN,
		S_FIN
	} state_t;

	state_t                          state_q;
	logic [ole_pkg::CNT_W-1:0]       count_q;
	logic [ole_pkg::CNT_W-1:0]       rp_q;
	logic [ole_pkg::CNT_W-1:0]       rem_q;
	logic [ole_pkg::ADDR_W-1:0]      pa_q;
	logic                            pv_q;
	logic                            found_q;
	logic [ole_pkg::ADDR_W-1:0]      idx_q;
	logic [ole_pkg::VALUE_W-1:0]     val_q;
	ole_pkg::status_t                res_q;
	logic                            out_valid_q;
	ole_pkg::status_t                out_status_q;
	logic [ole_pkg::LEN_W-1:0]       out_len_q;

	logic                            ram_we;
	logic [ole_pkg::ADDR_W-1:0]      ram_waddr;
	logic [ole_pkg::VALUE_W-1:0]     ram_wdata;
	logic                            ram_re;
	logic [ole_pkg::VALUE_W-1:0]     ram_rdata;

	logic [ole_pkg::CMP_W-1:0]       pos_x;
	logic [ole_pkg::CMP_W-1:0]       cnt_x;
	logic                            full;

	ole_ram #(
		.WIDTH (ole_pkg::VALUE_W),
		.DEPTH (ole_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rp_q[ole_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign pos_x = ole_pkg::CMP_W'(req.position);
	assign cnt_x = ole_pkg::CMP_W'(count_q);
	assign full  = (count_q == ole_pkg::CNT_W'(ole_pkg::CAPACITY));

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.length = out_len_q;

	assign ram_re = ((state_q == S_UP) || (state_q == S_DN)) && (rem_q != '0);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pa_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_UP: begin
				ram_we    = pv_q;
				ram_waddr = pa_q + ole_pkg::ADDR_W'(1);
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = val_q;
			end
			S_DN: begin
				ram_we    = pv_q && found_q;
				ram_waddr = pa_q - ole_pkg::ADDR_W'(1);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			pv_q         <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			rp_q         <= '0;
			rem_q        <= '0;
			pa_q         <= '0;
			idx_q        <= '0;
			val_q        <= '0;
			res_q        <= ole_pkg::ST_DONE;
			out_status_q <= ole_pkg::ST_DONE;
			out_len_q    <= '0;
		end else begin
			if (out_valid_q && rsp.ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						val_q <= req.value;
						pv_q  <= 1'b0;
						res_q <= ole_pkg::ST_DONE;
						case (req.cmd)
							ole_pkg::CMD_APPEND: begin
								if (full) begin
									res_q   <= ole_pkg::ST_FULL;
									state_q <= S_FIN;
								end else begin
									idx_q   <= count_q[ole_pkg::ADDR_W-1:0];
									rem_q   <= '0;
									state_q <= S_UP;
								end
							end
							ole_pkg::CMD_INSERT: begin
								if (full) begin
									res_q   <= ole_pkg::ST_FULL;
									state_q <= S_FIN;
								end else if (pos_x == '0 ||
								             pos_x > cnt_x + ole_pkg::CMP_W'(1)) begin
									res_q   <= ole_pkg::ST_BADPOS;
									state_q <= S_FIN;
								end else begin
									// shift slots count-1 down to pos-1 back by one
									idx_q   <= ole_pkg::ADDR_W'(req.position - 1'b1);
									rp_q    <= count_q - ole_pkg::CNT_W'(1);
									rem_q   <= ole_pkg::CNT_W'(cnt_x - pos_x + ole_pkg::CMP_W'(1));
									state_q <= S_UP;
								end
							end
							ole_pkg::CMD_DEL_POS: begin
								if (pos_x == '0 || pos_x > cnt_x) begin
									res_q   <= ole_pkg::ST_BADPOS;
									state_q <= S_FIN;
								end else begin
									found_q <= 1'b1;
									rp_q    <= ole_pkg::CNT_W'(req.position);
									rem_q   <= ole_pkg::CNT_W'(cnt_x - pos_x);
									state_q <= S_DN;
								end
							end
							default: begin
								found_q <= 1'b0;
								rp_q    <= '0;
								rem_q   <= count_q;
								state_q <= S_DN;
							end
						endcase
					end
				end
				S_UP: begin
					if (rem_q != '0) begin
						pa_q  <= rp_q[ole_pkg::ADDR_W-1:0];
						pv_q  <= 1'b1;
						rp_q  <= rp_q - ole_pkg::CNT_W'(1);
						rem_q <= rem_q - ole_pkg::CNT_W'(1);
					end else begin
						pv_q <= 1'b0;
						if (!pv_q) begin
							state_q <= S_PUT;
						end
					end
				end
				S_PUT: begin
					count_q <= count_q + ole_pkg::CNT_W'(1);
					state_q <= S_FIN;
				end
				S_DN: begin
					// first match stops the search; later entries move forward
					if (pv_q && !found_q && (ram_rdata == val_q)) begin
						found_q <= 1'b1;
					end
					if (rem_q != '0) begin
						pa_q  <= rp_q[ole_pkg::ADDR_W-1:0];
						pv_q  <= 1'b1;
						rp_q  <= rp_q + ole_pkg::CNT_W'(1);
						rem_q <= rem_q - ole_pkg::CNT_W'(1);
					end else begin
						pv_q <= 1'b0;
						if (!pv_q) begin
							if (found_q) begin
								count_q <= count_q - ole_pkg::CNT_W'(1);
							end else begin
								res_q <= ole_pkg::ST_NOTFOUND;
							end
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					// hold the result until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_q;
						out_len_q    <= ole_pkg::LEN_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> tb/sv/ordered_list_engine_test.sv
// Self-checking testbench for the ordered list engine: command stream, list predictor, response check.
`timescale 1ns / 1ps

module ordered_list_engine_test;

	localparam int CYCLE_LIMIT = 2_500_000;
	localparam int REPORT_MAX  = 10;

	typedef struct {
		ole_pkg::cmd_t                       op;
		logic signed [ole_pkg::VALUE_W-1:0]  value;
		logic [ole_pkg::POS_W-1:0]           position;
	} list_cmd_t;

	typedef struct {
		ole_pkg::status_t            status;
		logic [ole_pkg::LEN_W-1:0]   length;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                cmd_valid = 1'b0;
	ole_pkg::cmd_t                       cmd_op = ole_pkg::CMD_APPEND;
	logic signed [ole_pkg::VALUE_W-1:0]  cmd_value = '0;
	logic [ole_pkg::POS_W-1:0]           cmd_pos = '0;
	logic                                rsp_ready = 1'b0;

	ole_cmd_if cmd_ch ();
	ole_rsp_if rsp_ch ();

	assign cmd_ch.valid    = cmd_valid;
	assign cmd_ch.cmd      = cmd_op;
	assign cmd_ch.value    = cmd_value;
	assign cmd_ch.position = cmd_pos;
	assign rsp_ch.ready    = rsp_ready;

	ordered_list_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd_ch),
		.rsp    (rsp_ch)
	);

	logic signed [ole_pkg::VALUE_W-1:0] list_image[$];
	list_cmd_t cmd_backlog[$];
	list_rsp_t rsp_due[$];
	list_cmd_t active_cmd;
	list_rsp_t rsp_want;
	int cmds_sent = 0;
	int faults = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int phase_end[2];
	int backlog_total;

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one command to the list image and return the response it earns.
	function automatic list_rsp_t list_execute(list_cmd_t c);
		list_rsp_t r;
		int n;
		int hit;
		n = list_image.size();
		r.status = ole_pkg::ST_DONE;
		case (c.op)
		ole_pkg::CMD_APPEND: begin
			if (n >= ole_pkg::CAPACITY)
				r.status = ole_pkg::ST_FULL;
			else
				list_image.push_back(c.value);
		end
		ole_pkg::CMD_INSERT: begin
			// full takes precedence over a bad position
			if (n >= ole_pkg::CAPACITY)
				r.status = ole_pkg::ST_FULL;
			else if (c.position == 0 || int'(c.position) > n + 1)
				r.status = ole_pkg::ST_BADPOS;
			else
				list_image.insert(int'(c.position) - 1, c.value);
		end
		ole_pkg::CMD_DEL_POS: begin
			if (c.position == 0 || int'(c.position) > n)
				r.status = ole_pkg::ST_BADPOS;
			else
				list_image.delete(int'(c.position) - 1);
		end
		default: begin
			hit = -1;
			for (int i = 0; i < n; i++) begin
				if (hit < 0 && list_image[i] == c.value)
					hit = i;
			end
			if (hit < 0)
				r.status = ole_pkg::ST_NOTFOUND;
			else
				list_image.delete(hit);
		end
		endcase
		r.length = ole_pkg::LEN_W'(list_image.size());
		return r;
	endfunction

	function automatic list_cmd_t mk_cmd(ole_pkg::cmd_t op,
			logic signed [ole_pkg::VALUE_W-1:0] v, logic [ole_pkg::POS_W-1:0] p);
		list_cmd_t c;
		c.op = op;
		c.value = v;
		c.position = p;
		return c;
	endfunction

	// Queue a command and advance the list image so later choices see its effect.
	task automatic queue_cmd(list_cmd_t c);
		cmd_backlog.push_back(c);
		void'(list_execute(c));
	endtask

	function automatic logic signed [ole_pkg::VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return $urandom;
		// small values give plenty of duplicates
		if (r < 85)
			return ole_pkg::VALUE_W'(int'($urandom_range(6)) - 3);
		if (r < 92)
			return {1'b1, {(ole_pkg::VALUE_W-1){1'b0}}};
		return {1'b0, {(ole_pkg::VALUE_W-1){1'b1}}};
	endfunction

	function automatic list_cmd_t random_cmd();
		list_cmd_t c;
		int n;
		int grow;
		int pick;
		n = list_image.size();
		c.value = pick_value();
		c.position = ole_pkg::POS_W'($urandom_range((1 << ole_pkg::POS_W) - 1));
		c.op = ole_pkg::cmd_t'($urandom_range(3));
		if ($urandom_range(99) < 10)
			return c;
		grow = (n < 40) ? 65 : ((n > 140) ? 25 : 48);
		if ($urandom_range(99) < grow) begin
			c.op = ($urandom_range(2) == 0) ? ole_pkg::CMD_APPEND : ole_pkg::CMD_INSERT;
			c.position = ole_pkg::POS_W'($urandom_range(n + 1, 1));
		end else begin
			pick = $urandom_range(9);
			if (pick < 5) begin
				c.op = ole_pkg::CMD_DEL_POS;
				c.position = ole_pkg::POS_W'($urandom_range(n, 1));
			end else begin
				c.op = ole_pkg::CMD_DEL_VAL;
				if (pick < 9 && n > 0)
					c.value = list_image[$urandom_range(n - 1)];
			end
		end
		return c;
	endfunction

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++)
			queue_cmd(random_cmd());
	endtask

	// Grow the list to capacity, then probe the edges of a full list.
	task automatic fill_to_capacity();
		int n;
		while (list_image.size() < ole_pkg::CAPACITY) begin
			n = list_image.size();
			if ($urandom_range(1) == 0)
				queue_cmd(mk_cmd(ole_pkg::CMD_APPEND, pick_value(), '0));
			else
				queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, pick_value(),
					ole_pkg::POS_W'($urandom_range(n + 1, 1))));
		end
		queue_cmd(mk_cmd(ole_pkg::CMD_APPEND, pick_value(), '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, pick_value(), '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, pick_value(), {ole_pkg::POS_W{1'b1}}));
		queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, pick_value(), ole_pkg::POS_W'(1)));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_POS, pick_value(),
			ole_pkg::POS_W'(ole_pkg::CAPACITY + 1)));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_POS, pick_value(),
			ole_pkg::POS_W'(ole_pkg::CAPACITY)));
		queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, pick_value(),
			ole_pkg::POS_W'(ole_pkg::CAPACITY + 1)));
		queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, pick_value(),
			ole_pkg::POS_W'(ole_pkg::CAPACITY)));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_VAL,
			list_image[$urandom_range(ole_pkg::CAPACITY - 1)], '0));
	endtask

	// Driver: hold the command until it transfers, predict on transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ch.ready) begin
				rsp_due.push_back(list_execute(active_cmd));
				cmds_sent++;
			end
			if (!cmd_valid || cmd_ch.ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
					active_cmd = cmd_backlog.pop_front();
					cmd_valid <= 1'b1;
					cmd_op <= active_cmd.op;
					cmd_value <= active_cmd.value;
					cmd_pos <= active_cmd.position;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each response transfer with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ready) begin
				if (rsp_due.size() == 0) begin
					faults++;
					if (faults <= REPORT_MAX)
						$display("unexpected response: status %0d length %0d",
							rsp_ch.status, rsp_ch.length);
				end else begin
					rsp_want = rsp_due.pop_front();
					if (rsp_ch.status !== rsp_want.status ||
							rsp_ch.length !== rsp_want.length) begin
						faults++;
						if (faults <= REPORT_MAX)
							$display("response mismatch: status %0d (expected %0d) %s%0d (expected %0d)",
								rsp_ch.status, rsp_want.status, "length ",
								rsp_ch.length, rsp_want.length);
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("ordered_list_engine_test: errors");
			$finish;
		end
	end

	initial begin
		// empty list and position edges
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_POS, '0, ole_pkg::POS_W'(1)));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_VAL, '0, '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, 32'sh1234_5678, '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, 32'sh1234_5678, ole_pkg::POS_W'(2)));
		queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, {1'b1, {(ole_pkg::VALUE_W-1){1'b0}}},
			ole_pkg::POS_W'(1)));
		queue_cmd(mk_cmd(ole_pkg::CMD_APPEND, {1'b0, {(ole_pkg::VALUE_W-1){1'b1}}},
			{ole_pkg::POS_W{1'b1}}));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_POS, '0, '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_POS, '0, ole_pkg::POS_W'(3)));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_POS, '0, {ole_pkg::POS_W{1'b1}}));
		queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, '0, {ole_pkg::POS_W{1'b1}}));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_VAL, '0, '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, '1, ole_pkg::POS_W'(3)));
		queue_cmd(mk_cmd(ole_pkg::CMD_INSERT, '0, ole_pkg::POS_W'(2)));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_VAL, {1'b0, {(ole_pkg::VALUE_W-1){1'b1}}}, '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_POS, '0, ole_pkg::POS_W'(3)));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_POS, '0, ole_pkg::POS_W'(1)));
		// second position of a one-entry list
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_POS, '0, ole_pkg::POS_W'(2)));
		queue_cmd(mk_cmd(ole_pkg::CMD_APPEND, '0, '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_VAL, '0, '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_VAL, '0, '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_VAL, '0, '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_APPEND, 32'sh5555_5555, '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_APPEND, 32'shAAAA_AAAA, '0));
		queue_cmd(mk_cmd(ole_pkg::CMD_DEL_VAL, 32'shAAAA_AAAA, '0));

		queue_random(250);
		fill_to_capacity();
		queue_random(120);
		phase_end[0] = cmd_backlog.size();
		queue_random(450);
		phase_end[1] = cmd_backlog.size();
		queue_random(250);
		fill_to_capacity();
		queue_random(100);
		backlog_total = cmd_backlog.size();

		// start prediction again from the reset state
		list_image.delete();
		send_idle = 9;
		recv_idle = 86;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (cmds_sent < phase_end[0])
			@(posedge clk);
		send_idle = 86;
		recv_idle = 9;
		while (cmds_sent < phase_end[1])
			@(posedge clk);
		send_idle = 0;
		recv_idle = 0;
		while (cmds_sent < backlog_total || rsp_due.size() != 0)
			@(posedge clk);
		repeat (ole_pkg::CAPACITY + 10) @(posedge clk);

		if (faults == 0 && rsp_due.size() == 0) begin
			$display("ordered_list_engine_test: clean");
		end else begin
			$display("ordered_list_engine_test: errors");
		end
		$finish;
	end

endmodule
